/* rtl/core/ilid_pkg.sv */
// Shared types, widths and codes for the indexed list block.
package ilid_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        KIND_GET      = 3'd0,
        KIND_ADD_HEAD = 3'd1,
        KIND_ADD_TAIL = 3'd2,
        KIND_ADD_AT   = 3'd3,
        KIND_DEL_AT   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

/* rtl/core/ilid_cell.sv */
// One list slot: holds an entry and shifts it to or from its neighbors.
module ilid_cell (
    input  logic                           i_clk,
    input  logic [ilid_pkg::CMP_W-1:0]     i_index,
    input  ilid_pkg::t_cell_cmd            i_cmd,
    input  logic [ilid_pkg::VAL_W-1:0]     i_lower,
    input  logic [ilid_pkg::VAL_W-1:0]     i_upper,
    output logic [ilid_pkg::VAL_W-1:0]     o_value,
    output logic [ilid_pkg::VAL_W-1:0]     o_read
);

    logic [ilid_pkg::VAL_W-1:0] r_value;
    logic [ilid_pkg::VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (i_index > i_cmd.pos) begin
                n_value = i_lower;
            end else if (i_index == i_cmd.pos) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (i_index >= i_cmd.pos) begin
                n_value = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // Drive the read bus only from the addressed slot.
    assign o_read  = (i_index == i_cmd.pos) ? r_value : '0;

endmodule

/* rtl/core/indexed_list_insert_delete.sv */
// Top level of the indexed list: request decode, cell chain and result register.
//
// Usage:
//   Each request on the slave stream carries one list operation: kind in
//   s_axis_tuser, position and value in s_axis_tdata. Every request gives
//   exactly one result on the master stream with the value read, a status
//   code and the list length after the operation.
//   The list lives in a chain of CAPACITY cells. An insert shifts every cell
//   at or above the position up by one, a delete shifts them down by one,
//   all in the same cycle. The result is valid in the cycle after the
//   request is accepted. Throughput: one request per cycle while results
//   are taken; the result register is the only buffer.
//   Stall: while a result waits and m_axis_tready is low, s_axis_tready is
//   low; a result taken in the same cycle frees the register for the next.
//   Reset (i_rst_n low, synchronous): empties the list and drops any
//   pending result. Cell contents are not cleared; a slot is only read
//   after it was written.
module indexed_list_insert_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [6:0] position, [38:7] item_value, [39] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [31:0] read_value, [33:32] status,
                                        // [40:34] length_after, [47:41] zero
);

    localparam int CAP   = ilid_pkg::CAPACITY;
    localparam int CMP_W = ilid_pkg::CMP_W;
    localparam int VAL_W = ilid_pkg::VAL_W;
    localparam int CNT_W = ilid_pkg::CNT_W;

    logic                     fire;
    ilid_pkg::t_kind          kind;
    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         cnt_c;
    logic [VAL_W-1:0]         in_value;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic [47:0]              r_out_data;

    ilid_pkg::t_cell_cmd      cmd;
    ilid_pkg::t_status        status;
    logic                     do_ins;
    logic                     do_del;
    logic                     get_ok;
    logic [CMP_W-1:0]         op_pos;
    logic [VAL_W-1:0]         rd_bus;
    logic [VAL_W-1:0]         rd_value;

    logic [VAL_W-1:0]         cell_val [CAP];
    logic [VAL_W-1:0]         cell_rd  [CAP];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign kind          = ilid_pkg::t_kind'(s_axis_tuser);
    assign pos_c         = CMP_W'(s_axis_tdata[6:0]);
    assign in_value      = s_axis_tdata[38:7];
    assign cnt_c         = CMP_W'(r_count);

    // Decode the request into a broadcast command for the chain.
    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        get_ok = 1'b0;
        op_pos = pos_c;
        status = ilid_pkg::ST_OK;
        unique case (kind)
            ilid_pkg::KIND_GET: begin
                if (pos_c < cnt_c) begin
                    get_ok = 1'b1;
                end else begin
                    status = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::KIND_ADD_HEAD,
            ilid_pkg::KIND_ADD_TAIL,
            ilid_pkg::KIND_ADD_AT: begin
                if (kind == ilid_pkg::KIND_ADD_HEAD) begin
                    op_pos = '0;
                end else if (kind == ilid_pkg::KIND_ADD_TAIL) begin
                    op_pos = cnt_c;
                end
                // Range check wins over the full check.
                if (op_pos > cnt_c) begin
                    status = ilid_pkg::ST_RANGE;
                end else if (r_count == CNT_W'(CAP)) begin
                    status = ilid_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            ilid_pkg::KIND_DEL_AT: begin
                if (pos_c < cnt_c) begin
                    do_del = 1'b1;
                end else begin
                    status = ilid_pkg::ST_RANGE;
                end
            end
            default: begin
                status = ilid_pkg::ST_RANGE;
            end
        endcase
    end

    assign cmd.ins   = fire && do_ins;
    assign cmd.del   = fire && do_del;
    assign cmd.pos   = op_pos;
    assign cmd.value = in_value;

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Cell chain: each cell sees its lower and upper neighbor.
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [VAL_W-1:0] lower;
        logic [VAL_W-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = cell_val[g-1];
        end
        if (g == CAP - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = cell_val[g+1];
        end
        ilid_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CMP_W'(g)),
            .i_cmd   (cmd),
            .i_lower (lower),
            .i_upper (upper),
            .o_value (cell_val[g]),
            .o_read  (cell_rd[g])
        );
    end

    // Only the addressed cell drives nonzero, so OR the read lines together.
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAP; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    assign rd_value = get_ok ? rd_bus : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next request replaces it.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {7'd0, 7'(n_count), status, rd_value};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAP))
        else $error("list length exceeds capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted request gave no result");

    a_count_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_count))
        else $error("list length changed without a request");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[33:32] == ilid_pkg::ST_FULL) |-> r_count == CNT_W'(CAP))
        else $error("full status reported on a list that is not full");

endmodule
